>>> rtl/ptw_pkg.sv
// Shared types, constants and descriptor decode for the translation walker.
`timescale 1ns / 1ps
package ptw_pkg;

    localparam int ENTRY_W = 9;          // 512 descriptors per table
    localparam int PAGE_W  = 36;         // physical page number width
    localparam int PA_W    = 48;
    localparam int FLAG_W  = 9;
    localparam int CFG_IDX_W = 2;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_IS_KERNEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KERN_BASE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_USER_TOP  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_PAGE = 2'd3;

    localparam logic [63:0] KERN_BASE_RST = 64'hFFFF_0000_0000_0000;
    localparam logic [63:0] USER_TOP_RST  = 64'h0000_FFFF_FFFF_FFFF;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_XLATE = 1'b1;

    // descriptor type codes, bits 1:0
    localparam logic [1:0] DESC_TABLE = 2'b11;
    localparam logic [1:0] DESC_BLOCK = 2'b01;

    typedef struct packed {
        logic              is_kernel;
        logic [63:0]       kern_min;
        logic [63:0]       user_max;
        logic [PAGE_W-1:0] root_page;
    } t_cfg;

    // protection flags from a final descriptor
    function automatic logic [FLAG_W-1:0] decode_flags(input logic [63:0] d);
        logic [FLAG_W-1:0] f;
        f[0] = 1'b1;
        f[1] = ~d[7];
        f[2] = ~d[53];
        f[3] = d[6];
        f[4] = d[6] & ~d[7];
        f[5] = ~d[54];
        f[6] = d[0];
        f[7] = d[10];
        f[8] = d[55];
        return f;
    endfunction

endpackage

>>> rtl/page_table_translation_walk_unit.sv
// Top level of the four-level translation table walker.
`timescale 1ns / 1ps
// Usage:
//   Command channel: an item is taken on a rising edge with start high and
//   busy low. i_mode selects a descriptor write (word i_word_index gets
//   i_word_value) or a translation of i_virtual_address.
//   Result: o_done strobes for one cycle with o_status, o_physical_address
//   and o_protection_flags; the receiver cannot stall, so the result is gone
//   after that cycle.
//   Sequence: a write, a rejected address or a root page outside the table
//   RAM gives its result in the cycle after the transfer; a walk reads one
//   descriptor per level (one to four levels), each a dependent read of the
//   table RAM, and registers its result after the last read. busy drops in
//   the cycle the result is shown, so the next item can follow at once;
//   items that need no walk are taken one per cycle.
//   Configuration: i_cfg_we writes register i_cfg_idx from i_cfg_data at
//   once, at any time; only change it while no item is in flight.
//   Reset: after i_rst_n the table RAM is zeroed by a clearing pass over
//   all TABLE_PAGES*512 words (8192 at the default) with busy held high.
module page_table_translation_walk_unit #(
    parameter int TABLE_PAGES = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_mode,
    input  logic [63:0]                 i_virtual_address,
    input  logic [12:0]                 i_word_index,
    input  logic [63:0]                 i_word_value,
    input  logic                        i_cfg_we,
    input  logic [ptw_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]                 i_cfg_data,
    output logic                        o_done,
    output logic                        o_status,
    output logic [ptw_pkg::PA_W-1:0]    o_physical_address,
    output logic [ptw_pkg::FLAG_W-1:0]  o_protection_flags
);
    import ptw_pkg::*;

    localparam int DEPTH  = TABLE_PAGES * 512;
    localparam int MEM_AW = $clog2(DEPTH);

    t_cfg               r_cfg;
    logic               mem_we;
    logic [MEM_AW-1:0]  mem_waddr;
    logic [63:0]        mem_wdata;
    logic               mem_re;
    logic [MEM_AW-1:0]  mem_raddr;
    logic [63:0]        mem_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.is_kernel <= 1'b0;
            r_cfg.kern_min  <= KERN_BASE_RST;
            r_cfg.user_max  <= USER_TOP_RST;
            r_cfg.root_page <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IS_KERNEL: r_cfg.is_kernel <= i_cfg_data[0];
                CFG_KERN_BASE: r_cfg.kern_min  <= i_cfg_data;
                CFG_USER_TOP:  r_cfg.user_max  <= i_cfg_data;
                CFG_ROOT_PAGE: r_cfg.root_page <= i_cfg_data[PAGE_W-1:0];
                default: ;
            endcase
        end
    end

    ptw_walk #(
        .TABLE_PAGES (TABLE_PAGES)
    ) u_walk (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_start            (start),
        .o_busy             (busy),
        .i_mode             (i_mode),
        .i_virtual_address  (i_virtual_address),
        .i_word_index       (i_word_index),
        .i_word_value       (i_word_value),
        .o_mem_we           (mem_we),
        .o_mem_waddr        (mem_waddr),
        .o_mem_wdata        (mem_wdata),
        .o_mem_re           (mem_re),
        .o_mem_raddr        (mem_raddr),
        .i_mem_rdata        (mem_rdata),
        .o_done             (o_done),
        .o_status           (o_status),
        .o_physical_address (o_physical_address),
        .o_protection_flags (o_protection_flags)
    );

    ptw_ram #(
        .WIDTH (64),
        .DEPTH (DEPTH)
    ) u_table_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );
endmodule

>>> rtl/ptw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ptw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/ptw_walk.sv
// Walk sequencer: clearing pass, descriptor writes and the level 0..3 table walk.
`timescale 1ns / 1ps
module ptw_walk #(
    parameter int TABLE_PAGES = 16,
    localparam int MEM_AW = $clog2(TABLE_PAGES * 512)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ptw_pkg::t_cfg             i_cfg,
    input  logic                      i_start,
    output logic                      o_busy,
    input  logic                      i_mode,
    input  logic [63:0]               i_virtual_address,
    input  logic [12:0]               i_word_index,
    input  logic [63:0]               i_word_value,
    output logic                      o_mem_we,
    output logic [MEM_AW-1:0]         o_mem_waddr,
    output logic [63:0]               o_mem_wdata,
    output logic                      o_mem_re,
    output logic [MEM_AW-1:0]         o_mem_raddr,
    input  logic [63:0]               i_mem_rdata,
    output logic                      o_done,
    output logic                      o_status,
    output logic [ptw_pkg::PA_W-1:0]  o_physical_address,
    output logic [ptw_pkg::FLAG_W-1:0] o_protection_flags
);
    import ptw_pkg::*;

    localparam int DEPTH = TABLE_PAGES * 512;
    localparam int PG_W  = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_WALK} t_state;

    t_state              r_state;
    logic [1:0]          r_level;
    logic [47:0]         r_va;
    logic [MEM_AW-1:0]   r_clr_addr;
    logic                r_done;
    logic                r_status;
    logic [PA_W-1:0]     r_pa;
    logic [FLAG_W-1:0]   r_flags;

    logic                accept;
    logic                wr_ok;
    logic                addr_bad;
    logic                root_ok;
    logic [1:0]          dtype;
    logic [PAGE_W-1:0]   next_page;
    logic                page_ok;
    logic                walk_on;
    logic                walk_fin;
    logic [1:0]          n_level;
    logic [ENTRY_W-1:0]  n_entry;
    logic [PA_W-1:0]     fin_pa;

    assign accept  = i_start && (r_state == S_IDLE);
    assign wr_ok   = 32'(i_word_index) < 32'(DEPTH);
    assign addr_bad = i_cfg.is_kernel ? (i_virtual_address < i_cfg.kern_min)
                                      : (i_virtual_address > i_cfg.user_max);
    assign root_ok = i_cfg.root_page < PAGE_W'(TABLE_PAGES);

    assign dtype     = i_mem_rdata[1:0];
    assign next_page = i_mem_rdata[47:12];
    assign page_ok   = next_page < PAGE_W'(TABLE_PAGES);
    assign n_level   = r_level + 2'd1;

    // table descriptor below level 3 to a page inside the RAM carries on; page at level 3 or block at 1/2 ends
    assign walk_on  = (r_level != 2'd3) && (dtype == DESC_TABLE) && page_ok;
    assign walk_fin = ((r_level == 2'd3) && (dtype == DESC_TABLE)) ||
                      (((r_level == 2'd1) || (r_level == 2'd2)) && (dtype == DESC_BLOCK));

    always_comb begin
        unique case (n_level)
            2'd1:    n_entry = r_va[38:30];
            2'd2:    n_entry = r_va[29:21];
            default: n_entry = r_va[20:12];
        endcase
    end

    always_comb begin
        unique case (r_level)
            2'd1:    fin_pa = {i_mem_rdata[47:30], r_va[29:0]};
            2'd2:    fin_pa = {i_mem_rdata[47:21], r_va[20:0]};
            default: fin_pa = {i_mem_rdata[47:12], r_va[11:0]};
        endcase
    end

    // memory port
    always_comb begin
        o_mem_we    = 1'b0;
        o_mem_waddr = r_clr_addr;
        o_mem_wdata = '0;
        o_mem_re    = 1'b0;
        o_mem_raddr = MEM_AW'({i_cfg.root_page[PG_W-1:0], i_virtual_address[47:39]});
        if (r_state == S_CLEAR) begin
            o_mem_we = 1'b1;
        end else if (accept && (i_mode == MODE_WRITE)) begin
            o_mem_we    = wr_ok;
            o_mem_waddr = MEM_AW'(i_word_index);
            o_mem_wdata = i_word_value;
        end
        if (accept && (i_mode == MODE_XLATE)) begin
            o_mem_re = !addr_bad && root_ok;
        end else if ((r_state == S_WALK) && walk_on) begin
            o_mem_re    = 1'b1;
            o_mem_raddr = MEM_AW'({next_page[PG_W-1:0], n_entry});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_done     <= 1'b0;
            r_level    <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + MEM_AW'(1);
                    if (r_clr_addr == MEM_AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_va     <= i_virtual_address[47:0];
                        r_level  <= 2'd0;
                        r_status <= 1'b0;
                        r_pa     <= '0;
                        r_flags  <= '0;
                        if (i_mode == MODE_WRITE) begin
                            r_done <= 1'b1;
                        end else if (addr_bad) begin
                            r_status <= 1'b1;
                            r_done   <= 1'b1;
                        end else if (!root_ok) begin
                            r_done <= 1'b1;
                        end else begin
                            r_state <= S_WALK;
                        end
                    end
                end
                S_WALK: begin
                    if (walk_on) begin
                        r_level <= n_level;
                    end else begin
                        r_state <= S_IDLE;
                        r_done  <= 1'b1;
                        if (walk_fin) begin
                            r_pa    <= fin_pa;
                            r_flags <= decode_flags(i_mem_rdata);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy             = (r_state != S_IDLE);
    assign o_done             = r_done;
    assign o_status           = r_status;
    assign o_physical_address = r_pa;
    assign o_protection_flags = r_flags;
endmodule

>>> dv/page_table_translation_walk_unit_tb.sv
// Self-checking testbench for the four-level translation table walker.
`timescale 1ns / 1ps
module page_table_translation_walk_unit_tb;
    import ptw_pkg::*;

    localparam int N_PAGES   = 16;
    localparam int ENTRIES   = 512;
    localparam int MEM_WORDS = N_PAGES * ENTRIES;

    typedef struct packed {
        logic        mode;
        logic [63:0] va;
        logic [12:0] widx;
        logic [63:0] wval;
    } t_cmd;

    typedef struct packed {
        logic              status;
        logic [PA_W-1:0]   pa;
        logic [FLAG_W-1:0] flags;
    } t_walk_res;

    logic                 i_clk              = 1'b0;
    logic                 i_rst_n            = 1'b0;
    logic                 start              = 1'b0;
    logic                 i_mode             = MODE_WRITE;
    logic [63:0]          i_virtual_address  = '0;
    logic [12:0]          i_word_index       = '0;
    logic [63:0]          i_word_value       = '0;
    logic                 i_cfg_we           = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx          = CFG_IS_KERNEL;
    logic [63:0]          i_cfg_data         = '0;
    logic                 busy;
    logic                 o_done;
    logic                 o_status;
    logic [PA_W-1:0]      o_physical_address;
    logic [FLAG_W-1:0]    o_protection_flags;

    t_cmd        pending_cmds[$];
    t_walk_res   due_results[$];
    logic [63:0] recent_va[$];
    logic [63:0] tbl_mem[MEM_WORDS];
    t_cfg        xlat_cfg;
    t_cfg        gen_cfg;
    bit          took_item = 1'b0;
    int          gap_pct   = 14;
    int          mismatches = 0;

    page_table_translation_walk_unit #(
        .TABLE_PAGES(N_PAGES)
    ) u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_mode             (i_mode),
        .i_virtual_address  (i_virtual_address),
        .i_word_index       (i_word_index),
        .i_word_value       (i_word_value),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .o_done             (o_done),
        .o_status           (o_status),
        .o_physical_address (o_physical_address),
        .o_protection_flags (o_protection_flags)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Applies one command to the table copy and returns what the walk yields.
    function automatic t_walk_res walk_outcome(input logic mode, input logic [63:0] va,
                                               input logic [12:0] widx,
                                               input logic [63:0] wval);
        t_walk_res   res;
        logic [63:0] d;
        logic [35:0] pg;
        logic [47:0] keep;
        logic        walking;
        int          lvl;
        res = '0;
        if (mode == MODE_WRITE) begin
            if (int'(widx) < MEM_WORDS) tbl_mem[widx] = wval;
            return res;
        end
        if (xlat_cfg.is_kernel ? (va < xlat_cfg.kern_min) : (va > xlat_cfg.user_max)) begin
            res.status = 1'b1;
            return res;
        end
        pg = xlat_cfg.root_page;
        walking = 1'b1;
        for (lvl = 0; lvl < 4 && walking; lvl++) begin
            d = (pg < N_PAGES) ? tbl_mem[int'(pg) * ENTRIES + int'(va[47 - 9*lvl -: 9])] : '0;
            if (d[1:0] == DESC_TABLE && lvl < 3) begin
                pg = d[47:12];
            end else begin
                walking = 1'b0;
                // page at level 3, block only at levels 1 and 2
                if (d[1:0] == DESC_TABLE || (d[1:0] == DESC_BLOCK && (lvl == 1 || lvl == 2))) begin
                    keep = (48'd1 << (39 - 9*lvl)) - 48'd1;
                    res.pa = (d[47:0] & ~keep & ~48'hFFF) | (va[47:0] & keep);
                    res.flags = {d[55], d[10], d[0], ~d[54], d[6] & ~d[7], d[6],
                                 ~d[53], ~d[7], 1'b1};
                end
            end
        end
        return res;
    endfunction

    // Results are checked before new transfers so a same-edge push cannot be popped.
    always @(posedge i_clk) begin : monitor
        t_walk_res want;
        if (!i_rst_n) begin
            foreach (tbl_mem[k]) tbl_mem[k] = '0;
            xlat_cfg.is_kernel = 1'b0;
            xlat_cfg.kern_min  = KERN_BASE_RST;
            xlat_cfg.user_max  = USER_TOP_RST;
            xlat_cfg.root_page = '0;
        end else begin
            if (o_done) begin
                if (due_results.size() == 0) begin
                    $display("%0t: result with none expected: status %0b pa %h flags %h",
                             $time, o_status, o_physical_address, o_protection_flags);
                    mismatches++;
                end else begin
                    want = due_results.pop_front();
                    if (o_status !== want.status) begin
                        $display("%0t: status expected %0b got %0b",
                                 $time, want.status, o_status);
                        mismatches++;
                    end
                    if (o_physical_address !== want.pa) begin
                        $display("%0t: physical_address expected %h got %h",
                                 $time, want.pa, o_physical_address);
                        mismatches++;
                    end
                    if (o_protection_flags !== want.flags) begin
                        $display("%0t: protection_flags expected %h got %h",
                                 $time, want.flags, o_protection_flags);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_IS_KERNEL: xlat_cfg.is_kernel = i_cfg_data[0];
                    CFG_KERN_BASE: xlat_cfg.kern_min  = i_cfg_data;
                    CFG_USER_TOP:  xlat_cfg.user_max  = i_cfg_data;
                    CFG_ROOT_PAGE: xlat_cfg.root_page = i_cfg_data[PAGE_W-1:0];
                    default: ;
                endcase
            end
            if (start && !busy) begin
                due_results.push_back(walk_outcome(i_mode, i_virtual_address,
                                                   i_word_index, i_word_value));
                took_item = 1'b1;
            end
        end
    end

    always @(negedge i_clk) begin : driver
        t_cmd cmd;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || took_item) begin
            took_item = 1'b0;
            if (pending_cmds.size() != 0 && $urandom_range(99) >= gap_pct) begin
                cmd = pending_cmds.pop_front();
                start             <= 1'b1;
                i_mode            <= cmd.mode;
                i_virtual_address <= cmd.va;
                i_word_index      <= cmd.widx;
                i_word_value      <= cmd.wval;
            end else begin
                start <= 1'b0;
            end
        end
    end

    task automatic push_write(input logic [12:0] widx, input logic [63:0] wval);
        pending_cmds.push_back('{mode: MODE_WRITE, va: rand64(), widx: widx, wval: wval});
    endtask

    task automatic push_xlate(input logic [63:0] va);
        pending_cmds.push_back('{mode: MODE_XLATE, va: va, widx: 13'($urandom),
                                 wval: rand64()});
        recent_va.push_back(va);
        if (recent_va.size() > 16) void'(recent_va.pop_front());
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_IS_KERNEL: gen_cfg.is_kernel = data[0];
            CFG_KERN_BASE: gen_cfg.kern_min  = data;
            CFG_USER_TOP:  gen_cfg.user_max  = data;
            CFG_ROOT_PAGE: gen_cfg.root_page = data[PAGE_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Every command yields a result, so an empty expectation queue means idle.
    task automatic drain();
        do @(posedge i_clk);
        while (pending_cmds.size() != 0 || start || due_results.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic logic [63:0] make_va(input logic [8:0] l0, input logic [8:0] l1,
                                            input logic [8:0] l2, input logic [8:0] l3,
                                            input logic [11:0] off);
        return {16'h0000, l0, l1, l2, l3, off};
    endfunction

    // Mostly table paths written along a random in-range address, then lookups
    // into the mapped region; the rest is stray writes, wild addresses and repeated recent lookups.
    task automatic queue_random(input int n);
        int          left;
        int          last_lvl;
        int          lvl;
        logic [63:0] va;
        logic [63:0] d;
        logic [35:0] pg;
        logic [35:0] nxt;
        logic [47:0] span;
        left = n;
        while (left > 0) begin
            if ($urandom_range(9) == 0) begin
                if ($urandom_range(2) == 0) begin
                    push_write(13'($urandom), rand64());
                end else if ($urandom_range(1) == 0 || recent_va.size() == 0) begin
                    push_xlate(rand64());
                end else begin
                    push_xlate(recent_va[$urandom_range(recent_va.size() - 1)]);
                end
                left--;
            end else begin
                va = rand64();
                if (gen_cfg.is_kernel) begin
                    if (va < gen_cfg.kern_min) va |= gen_cfg.kern_min;
                end else if (va > gen_cfg.user_max) begin
                    va &= gen_cfg.user_max;
                end
                last_lvl = $urandom_range(3, 1);
                pg = gen_cfg.root_page;
                for (lvl = 0; lvl <= last_lvl && pg < N_PAGES; lvl++) begin
                    d = rand64();
                    nxt = '1;
                    if (lvl < last_lvl) begin
                        // now and then point past the memory or break the chain
                        nxt = ($urandom_range(29) == 0) ? (36'(rand64()) | 36'(N_PAGES))
                                                        : 36'($urandom_range(N_PAGES - 1));
                        d[47:12] = nxt;
                        d[1:0] = ($urandom_range(24) == 0) ? 2'($urandom_range(2)) : DESC_TABLE;
                    end else begin
                        d[1:0] = (lvl == 3) ? DESC_TABLE : DESC_BLOCK;
                        if ($urandom_range(15) == 0) d[1:0] = 2'($urandom);
                    end
                    push_write(13'(int'(pg) * ENTRIES + int'(va[47 - 9*lvl -: 9])), d);
                    pg = nxt;
                    left--;
                end
                span = (48'd1 << (39 - 9*last_lvl)) - 48'd1;
                repeat ($urandom_range(3, 1)) begin
                    push_xlate(va ^ {16'h0000, span & 48'(rand64())});
                    left--;
                end
            end
        end
    endtask

    initial begin
        gen_cfg.is_kernel = 1'b0;
        gen_cfg.kern_min  = KERN_BASE_RST;
        gen_cfg.user_max  = USER_TOP_RST;
        gen_cfg.root_page = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset defaults, user map, root in slot 0
        push_xlate(64'd0);
        push_xlate(USER_TOP_RST);
        push_xlate(USER_TOP_RST + 64'd1);
        push_xlate('1);
        push_write({4'd0, 9'd1}, (64'd1 << 12) | 64'(DESC_TABLE));
        push_write({4'd1, 9'd2}, (64'd2 << 12) | 64'(DESC_TABLE));
        push_write({4'd2, 9'd3}, (64'd3 << 12) | 64'(DESC_TABLE));
        push_write({4'd3, 9'd4}, '1);
        push_xlate(make_va(9'd1, 9'd2, 9'd3, 9'd4, 12'hFFF));
        push_write({4'd3, 9'd4}, 64'(DESC_TABLE));
        push_xlate(make_va(9'd1, 9'd2, 9'd3, 9'd4, 12'h000));
        push_write({4'd3, 9'd4}, 64'hFFFF_FFFF_FFFF_FFFD);   // block type at level 3
        push_xlate(make_va(9'd1, 9'd2, 9'd3, 9'd4, 12'h5A5));
        push_write({4'd2, 9'd3}, 64'h00A0_1234_5678_9441);   // 2 MB block
        push_xlate(make_va(9'd1, 9'd2, 9'd3, 9'd511, 12'hABC));
        push_write({4'd1, 9'd2}, 64'h0040_FFFF_C000_04C1);   // 1 GB block
        push_xlate(make_va(9'd1, 9'd2, 9'd511, 9'd511, 12'hFFF));
        push_write({4'd0, 9'd1}, 64'h0000_0000_0000_1001);   // block at level 0
        push_xlate(make_va(9'd1, 9'd2, 9'd3, 9'd4, 12'h000));
        push_write({4'd0, 9'd1}, (64'd16 << 12) | 64'(DESC_TABLE));
        push_xlate(make_va(9'd1, 9'd2, 9'd3, 9'd4, 12'h000));
        push_write(13'h1FFF, '1);
        push_write(13'h0000, '0);
        push_xlate(make_va(9'd0, 9'd0, 9'd0, 9'd0, 12'h000));
        drain();

        set_reg(CFG_IS_KERNEL, rand64() | 64'h1);
        set_reg(CFG_KERN_BASE, 64'hFFFF_8000_0000_0000);
        set_reg(CFG_ROOT_PAGE, {28'hABCDEF1, 36'd5});
        queue_random(300);
        drain();

        gap_pct = 70;
        set_reg(CFG_IS_KERNEL, rand64() & ~64'h1);
        set_reg(CFG_USER_TOP, 64'h0000_7FFF_FFFF_FFFF);
        set_reg(CFG_ROOT_PAGE, 64'd15);
        queue_random(300);
        drain();

        gap_pct = 0;
        set_reg(CFG_IS_KERNEL, 64'd1);
        set_reg(CFG_KERN_BASE, 64'd0);
        set_reg(CFG_ROOT_PAGE, 64'd0);
        queue_random(110);
        drain();
        set_reg(CFG_IS_KERNEL, 64'd0);
        set_reg(CFG_USER_TOP, '1);
        queue_random(110);
        drain();

        // limits at their extremes, then a root beyond the memory
        set_reg(CFG_IS_KERNEL, 64'd1);
        set_reg(CFG_KERN_BASE, '1);
        queue_random(20);
        drain();
        set_reg(CFG_IS_KERNEL, 64'd0);
        set_reg(CFG_USER_TOP, 64'd0);
        queue_random(20);
        drain();
        set_reg(CFG_USER_TOP, '1);
        set_reg(CFG_ROOT_PAGE, 64'h0000_000F_FFFF_FFFF);
        queue_random(20);
        drain();

        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && due_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

>>> page_table_translation_walk_unit.f
rtl/ptw_pkg.sv
rtl/ptw_ram.sv
rtl/ptw_walk.sv
rtl/page_table_translation_walk_unit.sv
dv/page_table_translation_walk_unit_tb.sv
